>>> hdl/aescbc_pkg.sv
package aescbc_pkg;

  localparam int NumRounds = 10;
  localparam int RndW = 4;
  localparam int CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_KEY_HIGH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_KEY_LOW  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_IV_HIGH  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_IV_LOW   = 2'd3;

  typedef logic [127:0] blk_t;

  typedef struct packed {
    logic            load;
    logic            step;
    logic [RndW-1:0] rnd;
  } key_ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] rcon(input logic [RndW-1:0] r);
    logic [7:0] v;
    unique case (r)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sub_rot(input logic [31:0] w, input logic [7:0] rc);
    return {SBOX[w[23:16]] ^ rc, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
  endfunction

  function automatic blk_t key_fwd(input blk_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3;
    w0 = k[127:96] ^ sub_rot(k[31:0], rc);
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic blk_t key_back(input blk_t k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3;
    w3 = k[31:0] ^ k[63:32];
    w2 = k[63:32] ^ k[95:64];
    w1 = k[95:64] ^ k[127:96];
    w0 = k[127:96] ^ sub_rot(w3, rc);
    return {w0, w1, w2, w3};
  endfunction

  function automatic blk_t inv_sub_shift(input blk_t s);
    blk_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (r + 4 * c) -: 8] =
          INV_SBOX[s[127 - 8 * (r + 4 * ((c - r + 4) % 4)) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic blk_t inv_mix(input blk_t s);
    blk_t t;
    logic [7:0] a [4];
    logic [7:0] a2 [4];
    logic [7:0] a4 [4];
    logic [7:0] a8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        a[r]  = s[127 - 8 * (r + 4 * c) -: 8];
        a2[r] = xt(a[r]);
        a4[r] = xt(a2[r]);
        a8[r] = xt(a4[r]);
        m9[r] = a8[r] ^ a[r];
        mb[r] = a8[r] ^ a2[r] ^ a[r];
        md[r] = a8[r] ^ a4[r] ^ a[r];
        me[r] = a8[r] ^ a4[r] ^ a2[r];
      end
      t[127 - 32 * c -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
      t[119 - 32 * c -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
      t[111 - 32 * c -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
      t[103 - 32 * c -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
    end
    return t;
  endfunction

endpackage

>>> hdl/aescbc_if.sv
interface aescbc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_high;
  logic [63:0] cipher_low;
  logic        restart;
  modport source (output valid, cipher_high, cipher_low, restart, input ready);
  modport sink (input valid, cipher_high, cipher_low, restart, output ready);
endinterface

interface aescbc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_high;
  logic [63:0] plain_low;
  modport source (output valid, plain_high, plain_low, input ready);
  modport sink (input valid, plain_high, plain_low, output ready);
endinterface

interface aescbc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [aescbc_pkg::CfgIdxW-1:0]  index;
  logic [63:0]                     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/aes128_cbc_decrypt_core.sv
// AES-128 CBC decryption core. One ciphertext word enters when the input is
// ready, runs one inverse round per cycle through a single shared round unit
// with the round keys rolled backward on the fly (the last round waits while
// the previous plaintext word is still unread), and is presented as a
// plaintext word; the input is ready again as soon as the result is
// registered, and no new word is taken while one is in its rounds. A write of
// either key register starts a key expansion (also run once after reset)
// during which no word is accepted. Chaining uses the previous ciphertext
// word, or the IV registers on restart and for the first word after reset.
module aes128_cbc_decrypt_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  aescbc_in_if.sink   blk_in_i,
  aescbc_out_if.source blk_out_o,
  aescbc_cfg_if.sink  cfg_i
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                          state_q, state_d;
  logic [aescbc_pkg::RndW-1:0]   rnd_q, rnd_d;
  aescbc_pkg::blk_t              key_q, key_d, iv_q, iv_d;
  aescbc_pkg::blk_t              chain_q, chain_d, chsel_q, chsel_d;
  logic                          loaded_q, loaded_d;
  aescbc_pkg::blk_t              out_q, out_d;
  logic                          ovalid_q, ovalid_d;
  logic                          in_acc, cfg_acc, key_wr, finish;
  aescbc_pkg::key_ctrl_t         kctrl;
  logic                          kbusy;
  aescbc_pkg::blk_t              last_key, next_key, fin, cipher;

  assign cipher        = {blk_in_i.cipher_high, blk_in_i.cipher_low};
  assign blk_in_i.ready = (state_q == ST_IDLE) && !kbusy;
  assign in_acc        = blk_in_i.valid && blk_in_i.ready;
  assign cfg_i.ready   = 1'b1;
  assign cfg_acc       = cfg_i.valid && cfg_i.ready;
  assign key_wr        = cfg_acc && (cfg_i.index == aescbc_pkg::CFG_KEY_HIGH ||
                                     cfg_i.index == aescbc_pkg::CFG_KEY_LOW);
  assign finish        = (state_q == ST_RUN) && (rnd_q == 4'd1) &&
                         (!ovalid_q || blk_out_o.ready);

  assign kctrl.load = in_acc;
  assign kctrl.step = (state_q == ST_RUN) && (rnd_q != 4'd1);
  assign kctrl.rnd  = rnd_q;

  aescbc_key_unit u_key (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .key_i    (key_d),
    .key_wr_i (key_wr),
    .ctrl_i   (kctrl),
    .busy_o   (kbusy),
    .last_o   (last_key),
    .next_o   (next_key)
  );

  aescbc_round_unit u_round (
    .clk_i      (clk_i),
    .load_i     (in_acc),
    .step_i     (kctrl.step),
    .cipher_i   (cipher),
    .last_key_i (last_key),
    .rkey_i     (next_key),
    .fin_o      (fin)
  );

  always_comb begin
    key_d    = key_q;
    iv_d     = iv_q;
    state_d  = state_q;
    rnd_d    = rnd_q;
    chain_d  = chain_q;
    chsel_d  = chsel_q;
    loaded_d = loaded_q;
    out_d    = out_q;
    ovalid_d = ovalid_q;
    if (cfg_acc) begin
      unique case (cfg_i.index)
        aescbc_pkg::CFG_KEY_HIGH: key_d[127:64] = cfg_i.data;
        aescbc_pkg::CFG_KEY_LOW:  key_d[63:0]   = cfg_i.data;
        aescbc_pkg::CFG_IV_HIGH:  iv_d[127:64]  = cfg_i.data;
        aescbc_pkg::CFG_IV_LOW:   iv_d[63:0]    = cfg_i.data;
        default: ;
      endcase
    end
    if (blk_out_o.valid && blk_out_o.ready) begin
      ovalid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          chsel_d  = (blk_in_i.restart || !loaded_q) ? iv_q : chain_q;
          chain_d  = cipher;
          loaded_d = 1'b1;
          rnd_d    = 4'(aescbc_pkg::NumRounds);
          state_d  = ST_RUN;
        end
      end
      ST_RUN: begin
        if (kctrl.step) begin
          rnd_d = rnd_q - 4'd1;
        end else if (finish) begin
          out_d    = fin ^ chsel_q;
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rnd_q    <= '0;
      key_q    <= '0;
      iv_q     <= '0;
      chain_q  <= '0;
      loaded_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rnd_q    <= rnd_d;
      key_q    <= key_d;
      iv_q     <= iv_d;
      chain_q  <= chain_d;
      loaded_q <= loaded_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chsel_q <= chsel_d;
    out_q   <= out_d;
  end

  assign blk_out_o.valid      = ovalid_q;
  assign blk_out_o.plain_high = out_q[127:64];
  assign blk_out_o.plain_low  = out_q[63:0];

endmodule

>>> hdl/aescbc_key_unit.sv
module aescbc_key_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  aescbc_pkg::blk_t      key_i,
  input  logic                  key_wr_i,
  input  aescbc_pkg::key_ctrl_t ctrl_i,
  output logic                  busy_o,
  output aescbc_pkg::blk_t      last_o,
  output aescbc_pkg::blk_t      next_o
);

  aescbc_pkg::blk_t                work_q, work_d;
  aescbc_pkg::blk_t                last_q, last_d;
  aescbc_pkg::blk_t                cur_q, cur_d;
  logic [aescbc_pkg::RndW-1:0]     cnt_q, cnt_d;
  logic                            busy_q, busy_d;
  aescbc_pkg::blk_t                fwd;

  assign fwd    = aescbc_pkg::key_fwd(work_q, aescbc_pkg::rcon(cnt_q));
  assign next_o = aescbc_pkg::key_back(cur_q, aescbc_pkg::rcon(ctrl_i.rnd));
  assign busy_o = busy_q;
  assign last_o = last_q;

  always_comb begin
    work_d = work_q;
    last_d = last_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    cur_d  = cur_q;
    if (key_wr_i) begin
      work_d = key_i;
      cnt_d  = 4'd1;
      busy_d = 1'b1;
    end else if (busy_q) begin
      work_d = fwd;
      cnt_d  = cnt_q + 4'd1;
      if (cnt_q == 4'(aescbc_pkg::NumRounds)) begin
        busy_d = 1'b0;
        last_d = fwd;
      end
    end
    if (ctrl_i.load) begin
      cur_d = last_q;
    end else if (ctrl_i.step) begin
      cur_d = next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q <= '0;
      cnt_q  <= 4'd1;
      busy_q <= 1'b1;
    end else begin
      work_q <= work_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= last_d;
    cur_q  <= cur_d;
  end

endmodule

>>> hdl/aescbc_round_unit.sv
module aescbc_round_unit (
  input  logic             clk_i,
  input  logic             load_i,
  input  logic             step_i,
  input  aescbc_pkg::blk_t cipher_i,
  input  aescbc_pkg::blk_t last_key_i,
  input  aescbc_pkg::blk_t rkey_i,
  output aescbc_pkg::blk_t fin_o
);

  aescbc_pkg::blk_t st_q, st_d;

  assign fin_o = aescbc_pkg::inv_sub_shift(st_q) ^ rkey_i;

  always_comb begin
    st_d = st_q;
    if (load_i) begin
      st_d = cipher_i ^ last_key_i;
    end else if (step_i) begin
      st_d = aescbc_pkg::inv_mix(fin_o);
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

endmodule

>>> hdl/aescbc_checker.sv
module aescbc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] plain_high,
  input logic [63:0] plain_low,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [aescbc_pkg::CfgIdxW-1:0] cfg_index
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(plain_high) && $stable(plain_low))
    else $error("output word changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> ##8 !in_ready)
    else $error("input ready while a word is still in its rounds");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid && cfg_ready &&
    (cfg_index == aescbc_pkg::CFG_KEY_HIGH || cfg_index == aescbc_pkg::CFG_KEY_LOW)
    |=> !in_ready)
    else $error("input ready during key expansion");

endmodule

bind aes128_cbc_decrypt_core aescbc_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (blk_in_i.valid),
  .in_ready   (blk_in_i.ready),
  .out_valid  (blk_out_o.valid),
  .out_ready  (blk_out_o.ready),
  .plain_high (blk_out_o.plain_high),
  .plain_low  (blk_out_o.plain_low),
  .cfg_valid  (cfg_i.valid),
  .cfg_ready  (cfg_i.ready),
  .cfg_index  (cfg_i.index)
);
